// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/hsiw_pkg.sv -----
package hsiw_pkg;

    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_NEAREST  = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;

    localparam int unsigned CFG_W  = 9;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NCHAN  = 4;
    localparam int unsigned ACC_W  = CHAN_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       wr_en;
        logic       rd_en;
        logic [1:0] tap;
        logic       acc_add;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       in_inside;
        logic       nearest;
        logic       out_free;
    } status_t;

endpackage

// ----- sv/hsiw_ctrl.sv -----
module hsiw_ctrl
    import hsiw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] tap_reg, tap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE: begin
                tap_next = '0;
                if (s_valid) begin
                    unique case (status.in_mode) inside
                        MODE_NEAREST, MODE_BILINEAR: begin
                            state_next = status.in_inside ? ST_RD : ST_DONE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                if (status.nearest || tap_reg == 2'd3) begin
                    state_next = ST_LAST;
                end else begin
                    tap_next = tap_reg + 2'd1;
                end
            end
            ST_LAST: state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        cmd.tap = tap_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                cmd.wr_en   = s_valid && status.in_inside && status.in_mode == MODE_WRITE;
            end
            ST_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.acc_add = tap_reg != 2'd0;
            end
            ST_LAST: cmd.acc_add  = 1'b1;
            ST_DONE: cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_port_exclusive, !(cmd.wr_en && cmd.rd_en), "frame write and read in one cycle")
    `ASSERT_RST(a_last_after_rd, (state_reg == ST_LAST) |-> $past(state_reg) == ST_RD, "last tap without reads")
    `ASSERT_RST(a_tap_in_rd, (state_reg == ST_RD && tap_reg != 2'd0) |-> $past(state_reg) == ST_RD, "tap count outside read phase")

endmodule

// ----- sv/hsiw_datapath.sv -----
module hsiw_datapath
    import hsiw_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        s_mode,
    input  logic [7:0]        s_row,
    input  logic [7:0]        s_col,
    input  logic [7:0]        s_in_red,
    input  logic [7:0]        s_in_green,
    input  logic [7:0]        s_in_blue,
    input  logic [7:0]        s_in_alpha,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_red,
    output logic [7:0]        m_out_green,
    output logic [7:0]        m_out_blue,
    output logic [7:0]        m_out_alpha,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  cmd_t              cmd,
    output status_t           status
);

    localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned SIDE_LIM = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    logic [CFG_W-1:0] height_reg, width_reg;
    logic [1:0]       mode_reg;
    logic [7:0]       row_reg, col_reg;
    logic             m_valid_reg;
    logic [31:0]      rd_data_reg;
    logic [NCHAN-1:0][ACC_W-1:0]  acc_reg;
    logic [NCHAN-1:0][CHAN_W-1:0] out_reg;
    logic [31:0]      frame_mem [DEPTH];

    logic              in_inside;
    logic [7:0]        tap_row, tap_col;
    logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= CFG_W'(256);
            width_reg  <= CFG_W'(256);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEIGHT: height_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_inside = (CFG_W'(s_row) < height_reg) && (CFG_W'(s_row) < CFG_W'(SIDE_LIM))
                    && (CFG_W'(s_col) < width_reg) && (CFG_W'(s_col) < CFG_W'(SIDE_LIM));

    assign tap_row  = {1'b0, row_reg[7:1]} + 8'(cmd.tap[1] & row_reg[0]);
    assign tap_col  = {1'b0, col_reg[7:1]} + 8'(cmd.tap[0] & col_reg[0]);
    assign wr_addr  = ADDR_W'(ADDR_W'(s_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(s_col));
    assign rd_addr  = ADDR_W'(ADDR_W'(tap_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(tap_col));
    assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            frame_mem[mem_addr] <= {s_in_alpha, s_in_blue, s_in_green, s_in_red};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= frame_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_mode;
            row_reg  <= s_row;
            col_reg  <= s_col;
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NCHAN; ch++) begin
            if (cmd.capture) begin
                acc_reg[ch] <= '0;
            end else if (cmd.acc_add) begin
                if (mode_reg == MODE_NEAREST) begin
                    acc_reg[ch] <= acc_reg[ch] + {rd_data_reg[ch*CHAN_W +: CHAN_W], 2'b00};
                end else begin
                    acc_reg[ch] <= acc_reg[ch] + {2'b00, rd_data_reg[ch*CHAN_W +: CHAN_W]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            for (int ch = 0; ch < NCHAN; ch++) begin
                out_reg[ch] <= acc_reg[ch][ACC_W-1:2];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_reg[0];
    assign m_out_green = out_reg[1];
    assign m_out_blue  = out_reg[2];
    assign m_out_alpha = out_reg[3];

    assign status.in_mode   = s_mode;
    assign status.in_inside = in_inside;
    assign status.nearest   = mode_reg == MODE_NEAREST;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

// ----- sv/half_scale_inverse_warp_sampler.sv -----
// 2x upscaler over a stored RGBA source frame of up to MAX_SIDE x MAX_SIDE pixels, held in a
// single-port frame memory with no clearing pass after reset; every pixel must be written
// before a sample reads it. Mode 0 writes one pixel when it is taken and gives no result,
// mode 3 is dropped. A sample reads its taps from the frame memory at one read per cycle
// (four taps for bilinear, one for nearest), then accumulates and loads the output
// register, which waits until that register is free; a sample outside the active frame
// skips the reads and returns zero. The output register lets a new item be taken while
// the previous result is still waiting on m_ready.
module half_scale_inverse_warp_sampler
    import hsiw_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [7:0]       s_row,
    input  logic [7:0]       s_col,
    input  logic [7:0]       s_in_red,
    input  logic [7:0]       s_in_green,
    input  logic [7:0]       s_in_blue,
    input  logic [7:0]       s_in_alpha,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic [7:0]       m_out_alpha,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    hsiw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hsiw_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_mode      (s_mode),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .s_in_alpha  (s_in_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- tb/tb_half_scale_inverse_warp_sampler.sv -----
module tb_half_scale_inverse_warp_sampler;
    import hsiw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int SIDE         = 256;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 13;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] pix;
    } warp_req_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [1:0]       s_mode      = '0;
    logic [7:0]       s_row       = '0;
    logic [7:0]       s_col       = '0;
    logic [7:0]       s_in_red    = '0;
    logic [7:0]       s_in_green  = '0;
    logic [7:0]       s_in_blue   = '0;
    logic [7:0]       s_in_alpha  = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [7:0]       m_out_red;
    logic [7:0]       m_out_green;
    logic [7:0]       m_out_blue;
    logic [7:0]       m_out_alpha;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index   = '0;
    logic [CFG_W-1:0] cfg_data    = '0;

    // stimulus side
    warp_req_t req_pending[$];
    bit        gen_written [65536];
    int        gen_rows = SIDE;
    int        gen_cols = SIDE;
    bit        steady_flow = 1'b0;

    // predictor side
    bit [31:0]        frame_mem [65536];
    logic [CFG_W-1:0] frame_height = CFG_W'(SIDE);
    logic [CFG_W-1:0] frame_width  = CFG_W'(SIDE);
    rgba_t            px_expected[$];

    logic in_taken   = 1'b0;
    int   mismatches = 0;
    int   cycle_count = 0;

    half_scale_inverse_warp_sampler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .s_in_alpha  (s_in_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 aclk = ~aclk;

    // expected pixel for an accepted sample, frame update for an accepted write
    task automatic upscale_step(input warp_req_t q);
        int          rows;
        int          cols;
        bit          in_frame;
        logic [7:0]  j;
        logic [7:0]  k;
        logic [7:0]  j1;
        logic [7:0]  k1;
        logic [31:0] taps [4];
        logic [31:0] word;
        logic [9:0]  sum;
        rows     = (frame_height > SIDE) ? SIDE : int'(frame_height);
        cols     = (frame_width > SIDE) ? SIDE : int'(frame_width);
        in_frame = (int'(q.row) < rows) && (int'(q.col) < cols);
        if (q.mode == MODE_WRITE) begin
            if (in_frame) begin
                frame_mem[{q.row, q.col}] = q.pix;
            end
        end else if (q.mode != MODE_UNUSED) begin
            word = '0;
            if (in_frame) begin
                j  = q.row >> 1;
                k  = q.col >> 1;
                j1 = j + q.row[0];
                k1 = k + q.col[0];
                taps[0] = frame_mem[{j, k}];
                taps[1] = frame_mem[{j, k1}];
                taps[2] = frame_mem[{j1, k}];
                taps[3] = frame_mem[{j1, k1}];
                if (q.mode == MODE_NEAREST) begin
                    word = taps[0];
                end else begin
                    for (int ch = 0; ch < NCHAN; ch++) begin
                        sum = taps[0][ch*8 +: 8] + taps[1][ch*8 +: 8]
                            + taps[2][ch*8 +: 8] + taps[3][ch*8 +: 8];
                        word[ch*8 +: 8] = sum[9:2];
                    end
                end
            end
            px_expected.push_back(rgba_t'(word));
        end
    endtask

    task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // input and output transfers, config writes
    always @(posedge aclk) begin : watch
        warp_req_t acc;
        rgba_t     want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HEIGHT) begin
                    frame_height = cfg_data;
                end else if (cfg_index == REG_WIDTH) begin
                    frame_width = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (px_expected.size() == 0) begin
                    $error("result transfer with no sample pending");
                    mismatches++;
                end else begin
                    want = px_expected.pop_front();
                    check_chan("out_red", want.red, m_out_red);
                    check_chan("out_green", want.green, m_out_green);
                    check_chan("out_blue", want.blue, m_out_blue);
                    check_chan("out_alpha", want.alpha, m_out_alpha);
                end
            end
            if (s_valid && s_ready) begin
                acc.mode = s_mode;
                acc.row  = s_row;
                acc.col  = s_col;
                acc.pix  = {s_in_alpha, s_in_blue, s_in_green, s_in_red};
                upscale_step(acc);
            end
        end
    end

    // input driver and result-side backpressure
    always @(negedge aclk) begin : feed
        warp_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (req_pending.size() != 0
                && (steady_flow || $urandom_range(99, 0) >= IDLE_PCT)) begin
                nxt = req_pending.pop_front();
                s_valid    <= 1'b1;
                s_mode     <= nxt.mode;
                s_row      <= nxt.row;
                s_col      <= nxt.col;
                s_in_red   <= nxt.pix[7:0];
                s_in_green <= nxt.pix[15:8];
                s_in_blue  <= nxt.pix[23:16];
                s_in_alpha <= nxt.pix[31:24];
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    task automatic push_req(input logic [1:0] mode, input logic [7:0] r, input logic [7:0] c,
                            input logic [31:0] pix);
        warp_req_t q;
        q.mode = mode;
        q.row  = r;
        q.col  = c;
        q.pix  = pix;
        req_pending.push_back(q);
    endtask

    function automatic bit gen_inside(input logic [7:0] r, input logic [7:0] c);
        return (int'(r) < gen_rows) && (int'(c) < gen_cols);
    endfunction

    task automatic add_write(input logic [7:0] r, input logic [7:0] c, input logic [31:0] pix);
        push_req(MODE_WRITE, r, c, pix);
        if (gen_inside(r, c)) begin
            gen_written[{r, c}] = 1'b1;
        end
    endtask

    task automatic fill_tap(input logic [7:0] r, input logic [7:0] c);
        if (!gen_written[{r, c}]) begin
            add_write(r, c, $urandom);
        end
    endtask

    // every source pixel a sample reads is written first
    task automatic add_sample(input logic [1:0] mode, input logic [7:0] r, input logic [7:0] c);
        logic [7:0] j;
        logic [7:0] k;
        if (gen_inside(r, c)) begin
            j = r >> 1;
            k = c >> 1;
            fill_tap(j, k);
            if (mode == MODE_BILINEAR) begin
                fill_tap(j, k + c[0]);
                fill_tap(j + r[0], k);
                fill_tap(j + r[0], k + c[0]);
            end
        end
        push_req(mode, r, c, $urandom);
    endtask

    task automatic make_random(input int n);
        int         pick;
        logic [7:0] r;
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            r = 8'($urandom);
            c = 8'($urandom);
            if (gen_rows > 0 && gen_cols > 0 && pick < 85) begin
                r = 8'($urandom_range(gen_rows - 1, 0));
                c = 8'($urandom_range(gen_cols - 1, 0));
            end
            if (pick < 45) begin
                add_sample(MODE_BILINEAR, r, c);
            end else if (pick < 70) begin
                add_sample(MODE_NEAREST, r, c);
            end else if (pick < 90) begin
                add_write(r, c, $urandom);
            end else if (pick < 95) begin
                add_sample(pick[0] ? MODE_BILINEAR : MODE_NEAREST, r, c);
            end else begin
                push_req(MODE_UNUSED, r, c, $urandom);
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w,
                             input bit spare);
        cfg_write(spare ? REG_SPARE_B : REG_SPARE_A, CFG_W'($urandom));
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_WIDTH, w);
        gen_rows = (h > SIDE) ? SIDE : int'(h);
        gen_cols = (w > SIDE) ? SIDE : int'(w);
    endtask

    task automatic drain();
        while (req_pending.size() != 0 || s_valid || px_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : run
        logic [CFG_W-1:0] heights [14];
        logic [CFG_W-1:0] widths  [14];
        heights = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd1, 9'd3, 9'd256,
                    9'd100, 9'd257, 9'd2, 9'd0, 9'd0, 9'd0, 9'd0};
        widths  = '{9'd256, 9'd2, 9'd300, 9'd17, 9'd1, 9'd256, 9'd2,
                    9'd37, 9'd9, 9'd256, 9'd0, 9'd0, 9'd0, 9'd0};
        for (int i = 10; i < 14; i++) begin
            heights[i] = CFG_W'($urandom_range(511, 0));
            widths[i]  = CFG_W'($urandom_range(511, 0));
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset-size frame: corner pixels, tap patterns, unused mode
        add_write(8'd0, 8'd0, 32'hFFFF_FFFF);
        add_write(8'd0, 8'd1, 32'h0000_0000);
        add_write(8'd1, 8'd0, 32'h00FF_00FF);
        add_write(8'd1, 8'd1, 32'hFF00_FF00);
        add_sample(MODE_NEAREST, 8'd0, 8'd0);
        add_sample(MODE_NEAREST, 8'd3, 8'd3);
        add_sample(MODE_BILINEAR, 8'd0, 8'd0);
        add_sample(MODE_BILINEAR, 8'd0, 8'd1);
        add_sample(MODE_BILINEAR, 8'd1, 8'd0);
        add_sample(MODE_BILINEAR, 8'd1, 8'd1);
        add_sample(MODE_BILINEAR, 8'd3, 8'd3);
        add_write(8'd255, 8'd255, 32'h8040_2010);
        add_sample(MODE_NEAREST, 8'd255, 8'd255);
        add_sample(MODE_BILINEAR, 8'd255, 8'd255);
        push_req(MODE_UNUSED, 8'd0, 8'd0, 32'h0);
        add_write(8'd0, 8'd0, 32'h0102_0304);
        add_sample(MODE_BILINEAR, 8'd1, 8'd1);
        add_sample(MODE_NEAREST, 8'd254, 8'd1);
        drain();

        for (int i = 0; i < 14; i++) begin
            set_frame(heights[i], widths[i], i[0]);
            steady_flow = (i == 0);
            make_random((i == 0) ? 150 : 75);
            drain();
            steady_flow = 1'b0;
        end

        if (px_expected.size() != 0) begin
            $error("%0d expected results never arrived", px_expected.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/hsiw_pkg.sv
sv/hsiw_ctrl.sv
sv/hsiw_datapath.sv
sv/half_scale_inverse_warp_sampler.sv
tb/tb_half_scale_inverse_warp_sampler.sv
